>>> src/lclc_pkg.sv
// ----------------------------------------------------------------------------
// lclc_pkg
// Shared types, register defaults and LED pattern tables of the LED chase
// and lock controller.
// ----------------------------------------------------------------------------
package lclc_pkg;

  localparam int unsigned LedW      = 9;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned PatDepth  = 14;

  localparam logic [LedW-1:0] LedAll = 9'h1FF;

  localparam logic [11:0] SleepLimitRst     = 12'd1200;
  localparam logic [7:0]  LockShortMinRst   = 8'd5;
  localparam logic [7:0]  LockLongTicksRst  = 8'd200;
  localparam logic [15:0] LightShortMinRst  = 16'd5;
  localparam logic [15:0] LightLongCountRst = 16'd2000;

  localparam logic [7:0] FlashOneSteps  = 8'd35;
  localparam logic [7:0] FlashTwoSteps  = 8'd33;
  localparam logic [7:0] FlashDarkSteps = 8'd3;
  localparam logic [7:0] ChaseOneSteps  = 8'd70;
  localparam logic [7:0] ChaseTwoSteps  = 8'd170;
  localparam logic [7:0] ChaseBlinkFrom = 8'd70;
  localparam logic [7:0] PatLastIdx     = 8'd13;
  localparam logic [10:0] IdleMax       = 11'h7FF;

  localparam logic [LedW-1:0] PatSet [PatDepth] = '{
    9'h000, 9'h008, 9'h004, 9'h002, 9'h001, 9'h100, 9'h080,
    9'h100, 9'h080, 9'h100, 9'h001, 9'h002, 9'h004, 9'h008};
  localparam logic [LedW-1:0] PatClr [PatDepth] = '{
    9'h008, 9'h004, 9'h002, 9'h001, 9'h100, 9'h080, 9'h000,
    9'h080, 9'h100, 9'h001, 9'h002, 9'h004, 9'h008, 9'h000};

  typedef enum logic [CfgIdxW-1:0] {
    CfgSleepLimit     = 3'd0,
    CfgLockShortMin   = 3'd1,
    CfgLockLongTicks  = 3'd2,
    CfgLightShortMin  = 3'd3,
    CfgLightLongCount = 3'd4
  } lclc_cfg_idx_e;

  typedef struct packed {
    logic [11:0] sleep_limit;
    logic [7:0]  lock_short_min;
    logic [7:0]  lock_long_ticks;
    logic [15:0] light_short_min;
    logic [15:0] light_long_count;
  } lclc_cfg_t;

  typedef struct packed {
    logic opcode;
    logic mode_key;
    logic light_key;
    logic lock_key;
  } lclc_item_t;

  typedef struct packed {
    logic [LedW-1:0] led_lines;
    logic            lock_state;
    logic            sleep_entered;
  } lclc_res_t;

  typedef struct packed {
    logic [15:0]     light_hold_count;
    logic            light_long_seen;
    logic [7:0]      lock_hold_count;
    logic            lock_long_seen;
    logic            locked;
    logic            chase_active;
    logic            flash_active;
    logic [7:0]      step_count;
    logic [1:0]      flash_round;
    logic [10:0]     idle_count;
    logic [LedW-1:0] led_state;
  } lclc_state_t;

  localparam lclc_state_t StateRst = '{
    locked:    1'b1,
    led_state: LedAll,
    default:   '0
  };

endpackage

>>> src/lclc_ifs.sv
// ----------------------------------------------------------------------------
// lclc interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface lclc_in_if ();
  logic valid;
  logic ready;
  logic opcode;
  logic mode_key;
  logic light_key;
  logic lock_key;

  modport source (output valid, opcode, mode_key, light_key, lock_key, input ready);
  modport sink (input valid, opcode, mode_key, light_key, lock_key, output ready);
endinterface

interface lclc_res_if import lclc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [LedW-1:0] led_lines;
  logic            lock_state;
  logic            sleep_entered;

  modport source (output valid, led_lines, lock_state, sleep_entered, input ready);
  modport sink (input valid, led_lines, lock_state, sleep_entered, output ready);
endinterface

interface lclc_cfg_if import lclc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/lclc_step.sv
// ----------------------------------------------------------------------------
// lclc_step
// Next-state and result logic for one main-loop pass: key handling, flash
// and chase patterns, and the idle counter.
// ----------------------------------------------------------------------------
module lclc_step import lclc_pkg::*; (
  input  lclc_state_t state_i,
  input  lclc_cfg_t   cfg_i,
  input  lclc_item_t  item_i,
  output lclc_state_t state_o,
  output lclc_res_t   res_o
);

  // Exact for every 8-bit value.
  function automatic logic [7:0] div5(logic [7:0] v);
    logic [15:0] p;
    p = 16'(v) * 16'd205;
    return {2'b00, p[15:10]};
  endfunction

  function automatic logic [LedW-1:0] apply_pat(logic [LedW-1:0] led, logic [7:0] idx);
    logic [LedW-1:0] res;
    res = led;
    if (idx <= PatLastIdx) begin
      res = (led | PatSet[idx[3:0]]) & ~PatClr[idx[3:0]];
    end
    return res;
  endfunction

  lclc_state_t s;
  logic        slept;
  logic        lock_ev;
  logic        end_flash;
  logic [7:0]  quo;
  logic [7:0]  pidx;

  always_comb begin
    s         = state_i;
    slept     = 1'b0;
    lock_ev   = 1'b0;
    end_flash = 1'b0;
    quo       = '0;
    pidx      = '0;

    if (item_i.light_key && s.light_hold_count != 16'hFFFF) begin
      s.light_hold_count = s.light_hold_count + 16'd1;
    end

    if (item_i.opcode) begin
      if (!item_i.light_key) begin
        if (s.light_hold_count > cfg_i.light_short_min) begin
          s.chase_active = 1'b1;
        end
        s.light_hold_count = '0;
        s.light_long_seen  = 1'b0;
      end else if (s.light_hold_count > cfg_i.light_long_count) begin
        s.light_hold_count = cfg_i.light_long_count;
        if (!s.light_long_seen) begin
          s.chase_active    = 1'b1;
          s.light_long_seen = 1'b1;
        end
      end

      if (item_i.lock_key) begin
        if (s.lock_hold_count != 8'hFF) begin
          s.lock_hold_count = s.lock_hold_count + 8'd1;
        end
        if (s.lock_hold_count >= cfg_i.lock_long_ticks) begin
          s.lock_hold_count = cfg_i.lock_long_ticks;
          if (!s.lock_long_seen) begin
            s.lock_long_seen = 1'b1;
            lock_ev          = 1'b1;
          end
        end
      end else begin
        if (s.lock_hold_count >= cfg_i.lock_long_ticks) begin
          s.lock_long_seen = 1'b0;
        end else if (s.lock_hold_count >= cfg_i.lock_short_min) begin
          lock_ev = 1'b1;
        end
        s.lock_hold_count = '0;
      end

      if (lock_ev) begin
        s.led_state    = LedAll;
        s.locked       = !s.locked;
        s.flash_active = 1'b1;
        s.step_count   = '0;
        s.flash_round  = '0;
      end

      if (s.flash_active) begin
        if (!item_i.mode_key) begin
          if (s.step_count < FlashOneSteps) begin
            s.led_state = apply_pat(s.led_state, div5(s.step_count));
          end
          s.step_count = s.step_count + 8'd1;
          end_flash    = (s.step_count >= FlashOneSteps);
        end else begin
          if (s.step_count < FlashDarkSteps) begin
            s.led_state = '0;
          end else if (s.step_count < FlashTwoSteps) begin
            s.led_state = LedAll;
          end
          s.step_count = s.step_count + 8'd1;
          end_flash    = (s.step_count >= FlashTwoSteps);
        end
        if (end_flash) begin
          s.step_count = '0;
          if (s.locked) begin
            s.flash_round = s.flash_round + 2'd1;
            if (s.flash_round == 2'd3) begin
              s.flash_active = 1'b0;
            end
          end else begin
            s.flash_active = 1'b0;
          end
        end
      end else if (s.chase_active) begin
        if (!s.locked) begin
          s.chase_active = 1'b0;
          s.step_count   = '0;
        end else begin
          pidx        = (s.step_count == 8'd0) ? 8'd0 : div5(s.step_count - 8'd1);
          s.led_state = apply_pat(s.led_state, pidx);
          if (!item_i.mode_key) begin
            s.step_count = s.step_count + 8'd1;
            if (s.step_count >= ChaseOneSteps) begin
              s.led_state    = LedAll;
              s.step_count   = '0;
              s.chase_active = 1'b0;
            end
          end else begin
            quo = div5(s.step_count);
            if (s.step_count >= ChaseBlinkFrom &&
                s.step_count == ({quo[5:0], 2'b00} + quo)) begin
              if (s.flash_round == 2'd0) begin
                s.led_state   = '0;
                s.flash_round = 2'd1;
              end else begin
                s.led_state   = LedAll;
                s.flash_round = 2'd0;
              end
            end
            s.step_count = s.step_count + 8'd1;
            if (s.step_count >= ChaseTwoSteps) begin
              s.led_state    = LedAll;
              s.flash_round  = '0;
              s.step_count   = '0;
              s.chase_active = 1'b0;
            end
          end
        end
      end

      if (s.step_count == 8'd0 && !s.chase_active &&
          (s.light_hold_count == 16'd0 || s.lock_long_seen)) begin
        if (s.idle_count != IdleMax) begin
          s.idle_count = s.idle_count + 11'd1;
        end
        if ({1'b0, s.idle_count} > cfg_i.sleep_limit) begin
          s.idle_count      = '0;
          s.led_state       = LedAll;
          s.lock_hold_count = '0;
          slept             = 1'b1;
        end
      end else begin
        s.idle_count = '0;
      end
    end

    state_o             = s;
    res_o.led_lines     = s.led_state;
    res_o.lock_state    = s.locked;
    res_o.sleep_entered = slept;
  end

endmodule

>>> src/led_chase_lock_controller.sv
// ----------------------------------------------------------------------------
// led_chase_lock_controller
// Lock key and light key handling with LED flash, chase and sleep request.
// ----------------------------------------------------------------------------
// Each input item is one main-loop pass; every item gives exactly one result
// item. An item is captured in an input register, then one pass of the key,
// pattern and idle logic updates the controller state and loads the result
// register, so the block takes one item per cycle while results are taken.
// The input register holds one further item while a result waits to be
// taken. Register writes complete in the cycle they are presented.
module led_chase_lock_controller import lclc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  lclc_in_if.sink           in_i,
  lclc_res_if.source        res_o,
  lclc_cfg_if.sink          cfg_i
);

  lclc_cfg_t   cfg_q;
  lclc_state_t state_q;
  lclc_state_t state_d;
  lclc_item_t  item_q;
  logic        item_valid_q;
  lclc_res_t   res_q;
  lclc_res_t   res_d;
  logic        res_valid_q;
  logic        advance;

  assign advance     = item_valid_q && (!res_valid_q || res_o.ready);
  assign in_i.ready  = !item_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sleep_limit      <= SleepLimitRst;
      cfg_q.lock_short_min   <= LockShortMinRst;
      cfg_q.lock_long_ticks  <= LockLongTicksRst;
      cfg_q.light_short_min  <= LightShortMinRst;
      cfg_q.light_long_count <= LightLongCountRst;
    end else if (cfg_i.valid) begin
      unique case (lclc_cfg_idx_e'(cfg_i.index))
        CfgSleepLimit:     cfg_q.sleep_limit      <= cfg_i.data[11:0];
        CfgLockShortMin:   cfg_q.lock_short_min   <= cfg_i.data[7:0];
        CfgLockLongTicks:  cfg_q.lock_long_ticks  <= cfg_i.data[7:0];
        CfgLightShortMin:  cfg_q.light_short_min  <= cfg_i.data;
        CfgLightLongCount: cfg_q.light_long_count <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.opcode    <= in_i.opcode;
      item_q.mode_key  <= in_i.mode_key;
      item_q.light_key <= in_i.light_key;
      item_q.lock_key  <= in_i.lock_key;
    end
  end

  lclc_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .item_i  (item_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateRst;
      res_valid_q <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.led_lines     = res_q.led_lines;
  assign res_o.lock_state    = res_q.lock_state;
  assign res_o.sleep_entered = res_q.sleep_entered;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (item_valid_q && res_valid_q && !res_o.ready))
    else $error("input stalled without a waiting result");

  a_advance_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_valid_q)
    else $error("processed item produced no result");

  a_sleep_leds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.sleep_entered) |-> (res_q.led_lines == LedAll))
    else $error("sleep request without all LED lines high");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("controller state changed without an item");

endmodule
